[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is asserted.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true at a rising edge.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/core/bdm_pkg.sv]
// ----------------------------------------------------------------------------
// bdm_pkg
// Types, register codes and defaults for the 5x5 Bayer demosaic unit.
// ----------------------------------------------------------------------------
package bdm_pkg;

	localparam int BDM_MAX_WIDTH   = 4096;
	localparam int BDM_SAMPLE_BITS = 12;

	localparam int FIELD_BITS    = 12;
	localparam int LW_BITS       = 13;
	localparam int FH_BITS       = 14;
	localparam int CFG_DATA_BITS = 14;
	localparam int CFG_IDX_BITS  = 1;
	// input row runs a few rows past the frame height while draining
	localparam int ROW_BITS      = FH_BITS + 1;

	typedef logic [FIELD_BITS-1:0]    field_t;
	typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;
	typedef logic [CFG_IDX_BITS-1:0]  cfg_idx_t;

	localparam cfg_idx_t REG_LINE_WIDTH   = 1'd0;
	localparam cfg_idx_t REG_FRAME_HEIGHT = 1'd1;

	localparam logic [LW_BITS-1:0] LW_RESET = 13'd640;
	localparam logic [FH_BITS-1:0] FH_RESET = 14'd480;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_FLUSH  = 1'b1;

endpackage

[rtl/core/bayer_demosaic_5x5_unit.sv]
// ----------------------------------------------------------------------------
// bayer_demosaic_5x5_unit
// Streaming RGGB demosaic with 5x5 Malvar-He-Cutler kernels, four line stores.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data
//  sample    in   sample_valid/_stall    command, raw_sample
//  pixel     out  pixel_valid/_stall     red, green, blue, frame_end
//
//  One request per clock unless the output stalls; a pixel leaves, registered,
//  after the request completing its window (2*line_width+2 after its sample).
//  The line store is one memory, one read and one write per cycle, RMW with
//  forwarding; a column is read at accept and written back one stage later.
//  Reset clears counters, stage valids and config registers; no clearing pass.
//  Stages stall independently; bubbles collapse, so a request is taken while
//  a finished pixel waits at the output.
`include "assert_macros.svh"

module bayer_demosaic_5x5_unit #(
	parameter int MAX_WIDTH   = bdm_pkg::BDM_MAX_WIDTH,
	parameter int SAMPLE_BITS = bdm_pkg::BDM_SAMPLE_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  bdm_pkg::cfg_idx_t  cfg_index,
	input  bdm_pkg::cfg_data_t cfg_data,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic               command,
	input  bdm_pkg::field_t    raw_sample,
	output logic               pixel_valid,
	input  logic               pixel_stall,
	output bdm_pkg::field_t    red,
	output bdm_pkg::field_t    green,
	output bdm_pkg::field_t    blue,
	output logic               frame_end
);
	import bdm_pkg::*;

	localparam int SB   = SAMPLE_BITS;
	localparam int CB   = $clog2(MAX_WIDTH);
	localparam int WB   = CB + 1;
	localparam int GB   = SB + 2;
	localparam int KB   = SB + 7;
	localparam int CMPB = (LW_BITS > WB) ? LW_BITS : WB;
	localparam logic [SB-1:0] SMAX = {SB{1'b1}};
	localparam logic signed [KB-1:0] RND = KB'(8);

	// ---------------- configuration ----------------
	logic [LW_BITS-1:0] lw_q;
	logic [FH_BITS-1:0] fh_q;
	logic [CMPB-1:0]    lw_ext;
	logic [WB-1:0]      w;
	logic [FH_BITS-1:0] h;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_q <= LW_RESET;
			fh_q <= FH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LINE_WIDTH:   lw_q <= cfg_data[LW_BITS-1:0];
				REG_FRAME_HEIGHT: fh_q <= cfg_data[FH_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign lw_ext = CMPB'(lw_q);

	always_comb begin
		if (lw_ext < CMPB'(2))
			w = WB'(2);
		else if (lw_ext > CMPB'(MAX_WIDTH))
			w = WB'(MAX_WIDTH);
		else
			w = WB'(lw_ext);
		h = (fh_q < FH_BITS'(2)) ? FH_BITS'(2) : fh_q;
	end

	// ---------------- stage flow ----------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic free_out, free1, free2, free3, free4;
	logic mv1, mv2, mv3, mv4;

	assign free_out     = !pixel_valid || !pixel_stall;
	assign mv4          = v_s4 && free_out;
	assign free4        = !v_s4 || free_out;
	assign mv3          = v_s3 && free4;
	assign free3        = !v_s3 || free4;
	assign mv2          = v_s2 && free3;
	assign free2        = !v_s2 || free3;
	assign mv1          = v_s1 && free2;
	assign free1        = !v_s1 || free2;
	assign sample_stall = !free1;

	// ---------------- raster counters ----------------
	logic [CB-1:0]       icol_q, ocol_q, icol, ocol;
	logic [ROW_BITS-1:0] irow_q, irow;
	logic [FH_BITS-1:0]  orow_q, orow, orow_n;
	logic [WB-1:0]       icol_inc, ocol_inc;
	logic [CB+1:0]       icol_x, w_x;
	logic                clr, draining, accept, proc, warm, emit, i_wrap, o_wrap, fend;

	always_comb begin
		clr      = orow_q >= h;   // height shrunk to or under the output row
		icol     = clr ? '0 : icol_q;
		irow     = clr ? '0 : irow_q;
		ocol     = clr ? '0 : ocol_q;
		orow     = clr ? '0 : orow_q;
		draining = irow >= ROW_BITS'(h);
		accept   = sample_valid && !sample_stall;
		proc     = accept && (draining || command != CMD_FLUSH);
		icol_inc = WB'(icol) + WB'(1);
		i_wrap   = icol_inc >= w;
		icol_x   = (CB+2)'(icol);
		w_x      = (CB+2)'(w);
		// window not yet filled: linear position below 2*w+2
		warm     = (irow == ROW_BITS'(0) && icol_x < (w_x << 1) + (CB+2)'(2)) ||
		           (irow == ROW_BITS'(1) && icol_x < w_x + (CB+2)'(2)) ||
		           (irow == ROW_BITS'(2) && icol < CB'(2));
		emit     = !warm;
		ocol_inc = WB'(ocol) + WB'(1);
		o_wrap   = ocol_inc >= w;
		orow_n   = o_wrap ? orow + FH_BITS'(1) : orow;
		fend     = orow_n >= h;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icol_q <= '0;
			irow_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (accept) begin
			if (proc && emit && fend) begin
				icol_q <= '0;
				irow_q <= '0;
				ocol_q <= '0;
				orow_q <= '0;
			end else if (proc) begin
				icol_q <= i_wrap ? '0 : icol_inc[CB-1:0];
				irow_q <= i_wrap ? irow + ROW_BITS'(1) : irow;
				ocol_q <= (emit && !o_wrap) ? ocol_inc[CB-1:0] : (emit ? '0 : ocol);
				orow_q <= emit ? orow_n : orow;
			end else begin
				icol_q <= icol;
				irow_q <= irow;
				ocol_q <= ocol;
				orow_q <= orow;
			end
		end
	end

	// ---------------- stage 1: line store read-modify-write ----------------
	logic [SB-1:0]      value_s1;
	logic [CB-1:0]      addr_s1, ocol_s1;
	logic [FH_BITS-1:0] orow_s1;
	logic               emit_s1, fend_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (free1)
			v_s1 <= proc;
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			value_s1 <= draining ? '0 : SB'(raw_sample);
			addr_s1  <= icol;
			emit_s1  <= emit;
			fend_s1  <= fend;
			orow_s1  <= orow;
			ocol_s1  <= ocol;
		end
	end

	logic [4*SB-1:0] lstore [MAX_WIDTH];
	logic [4*SB-1:0] rd_q, wr_word;
	logic [4:0][SB-1:0] col;

	always_comb begin
		for (int r = 0; r < 4; r++)
			col[r] = rd_q[r*SB +: SB];
		col[4]  = value_s1;
		wr_word = {col[4], col[3], col[2], col[1]};
	end

	always_ff @(posedge clk) begin
		if (mv1)
			lstore[addr_s1] <= wr_word;
		if (proc) begin
			if (mv1 && addr_s1 == icol)
				rd_q <= wr_word;
			else
				rd_q <= lstore[icol];
		end
	end

	// border masks of the pixel leaving stage 1
	logic [4:0] rmask, cmask;

	always_comb begin
		for (int d = 0; d < 5; d++) begin
			rmask[d] = ((d >= 2) || orow_s1 >= FH_BITS'(2 - d)) &&
			           ((FH_BITS+1)'(orow_s1) + (FH_BITS+1)'(d) <
			            (FH_BITS+1)'(h) + (FH_BITS+1)'(2));
			cmask[d] = ((d >= 2) || ocol_s1 >= CB'(2 - d)) &&
			           ((WB+1)'(ocol_s1) + (WB+1)'(d) < (WB+1)'(w) + (WB+1)'(2));
		end
	end

	// ---------------- stage 2: 5x5 window ----------------
	logic [4:0][4:0][SB-1:0] win_q;
	logic [4:0]              rmask_s2, cmask_s2;
	logic                    fend_s2, orow0_s2, ocol0_s2;

	always_ff @(posedge clk) begin
		if (mv1) begin
			for (int r = 0; r < 5; r++) begin
				for (int j = 0; j < 4; j++)
					win_q[r][j] <= win_q[r][j+1];
				win_q[r][4] <= col[r];
			end
			rmask_s2 <= rmask;
			cmask_s2 <= cmask;
			fend_s2  <= fend_s1;
			orow0_s2 <= orow_s1[0];
			ocol0_s2 <= ocol_s1[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (free2)
			v_s2 <= mv1 && emit_s1;
	end

	// ---------------- stage 3: grouped tap sums ----------------
	logic [4:0][4:0][SB-1:0] tap;
	logic [SB-1:0]           c_s3, nat_s3;
	logic [GB-1:0]           a_s3, b_s3, d_s3, e_s3, f_s3;
	logic                    fend_s3, orow0_s3, ocol0_s3;

	always_comb begin
		for (int r = 0; r < 5; r++)
			for (int j = 0; j < 5; j++)
				tap[r][j] = (rmask_s2[r] && cmask_s2[j]) ? win_q[r][j] : '0;
	end

	always_ff @(posedge clk) begin
		if (mv2) begin
			c_s3     <= tap[2][2];
			nat_s3   <= win_q[2][2];
			a_s3     <= GB'(tap[1][2]) + GB'(tap[3][2]);
			b_s3     <= GB'(tap[2][1]) + GB'(tap[2][3]);
			d_s3     <= GB'(tap[0][2]) + GB'(tap[4][2]);
			e_s3     <= GB'(tap[2][0]) + GB'(tap[2][4]);
			f_s3     <= GB'(tap[1][1]) + GB'(tap[1][3]) + GB'(tap[3][1]) + GB'(tap[3][3]);
			fend_s3  <= fend_s2;
			orow0_s3 <= orow0_s2;
			ocol0_s3 <= ocol0_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (free3)
			v_s3 <= mv2;
	end

	// ---------------- stage 4: kernel sums ----------------
	logic signed [KB-1:0] kc, ka, kb, kd, ke, kf;
	logic signed [KB-1:0] k1_s4, k2_s4;
	logic [SB-1:0]        nat_s4;
	logic                 fend_s4, orow0_s4, ocol0_s4, gsite;

	always_comb begin
		kc    = $signed(KB'(c_s3));
		ka    = $signed(KB'(a_s3));
		kb    = $signed(KB'(b_s3));
		kd    = $signed(KB'(d_s3));
		ke    = $signed(KB'(e_s3));
		kf    = $signed(KB'(f_s3));
		gsite = orow0_s3 ^ ocol0_s3;
	end

	// green site: k1 horizontal, k2 vertical; red/blue site: k1 green, k2 diagonal
	always_ff @(posedge clk) begin
		if (mv3) begin
			k1_s4    <= gsite ? KB'(10 * kc + 8 * kb - 2 * ke - 2 * kf + kd)
			                  : KB'(8 * kc + 4 * (ka + kb) - 2 * (kd + ke));
			k2_s4    <= gsite ? KB'(10 * kc + 8 * ka - 2 * kd - 2 * kf + ke)
			                  : KB'(12 * kc + 4 * kf - 3 * (kd + ke));
			nat_s4   <= nat_s3;
			fend_s4  <= fend_s3;
			orow0_s4 <= orow0_s3;
			ocol0_s4 <= ocol0_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (free4)
			v_s4 <= mv3;
	end

	// ---------------- output register ----------------
	function automatic logic [SB-1:0] rnd_clamp(input logic signed [KB-1:0] k);
		logic signed [KB-1:0] t;
		logic [KB-1:0]        q;
		logic [SB-1:0]        res;
		t = k + RND;
		q = KB'(t >>> 4);
		if (t < 0)
			res = '0;
		else if (q > KB'(SMAX))
			res = SMAX;
		else
			res = q[SB-1:0];
		return res;
	endfunction

	logic [SB-1:0] k1v, k2v;

	assign k1v = rnd_clamp(k1_s4);
	assign k2v = rnd_clamp(k2_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pixel_valid <= 1'b0;
		else if (free_out)
			pixel_valid <= mv4;
	end

	always_ff @(posedge clk) begin
		if (mv4) begin
			frame_end <= fend_s4;
			case ({orow0_s4, ocol0_s4})
				2'b00: begin
					red   <= FIELD_BITS'(nat_s4);
					green <= FIELD_BITS'(k1v);
					blue  <= FIELD_BITS'(k2v);
				end
				2'b11: begin
					red   <= FIELD_BITS'(k2v);
					green <= FIELD_BITS'(k1v);
					blue  <= FIELD_BITS'(nat_s4);
				end
				2'b01: begin
					red   <= FIELD_BITS'(k1v);
					green <= FIELD_BITS'(nat_s4);
					blue  <= FIELD_BITS'(k2v);
				end
				default: begin
					red   <= FIELD_BITS'(k2v);
					green <= FIELD_BITS'(nat_s4);
					blue  <= FIELD_BITS'(k1v);
				end
			endcase
		end
	end

	// ---------------- assertions ----------------
	`ASSERT_CLKD(a_rd_hold, clk, arst_n, (v_s1 && !mv1) |=> $stable(rd_q), "line store read data lost while stage 1 stalled")
	`ASSERT_CLKD(a_win_hold, clk, arst_n, (v_s2 && !mv2) |=> $stable(win_q), "window moved under a stalled pixel")
	`ASSERT_CLKD(a_frame_wrap, clk, arst_n, (proc && emit && fend) |=> (icol_q == '0 && irow_q == '0 && ocol_q == '0 && orow_q == '0), "counters not cleared after last pixel")
	`ASSERT_NEVER(a_fend_border, clk, arst_n, v_s2 && fend_s2 && rmask_s2[3], "last pixel of frame sees a row below the image")

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams raw RGGB frames through the 5x5 demosaic unit and checks every RGB
// pixel against a cycle-free model of the interpolation kernels, with random
// idling on both channels, mid-frame height changes and abandoned frames.
// ----------------------------------------------------------------------------
module tb_top;
	import bdm_pkg::*;

	localparam int LIMIT_CYCLES  = 8_000_000;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_ITEMS  = 1250;
	localparam int SAMPLE_MAX    = (1 << BDM_SAMPLE_BITS) - 1;

	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	typedef enum int {KERN_GREEN, KERN_HORIZ, KERN_VERT, KERN_DIAG} kern_e;
	typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_e;

	typedef struct packed {
		field_t red;
		field_t green;
		field_t blue;
		logic   frame_end;
	} pixel_t;

	class pixel_scoreboard;
		pixel_t             pixels_due[$];
		int                 errors;
		int                 in_row, in_column, out_row, out_column;
		logic [LW_BITS-1:0] width_reg;
		logic [FH_BITS-1:0] height_reg;
		field_t             store[4*BDM_MAX_WIDTH];
		field_t             win[5][5];
		int                 weights[4][5][5];

		function new();
			weights = '{
				'{'{0, 0, -2, 0, 0}, '{0, 0, 4, 0, 0}, '{-2, 4, 8, 4, -2},
				  '{0, 0, 4, 0, 0}, '{0, 0, -2, 0, 0}},
				'{'{0, 0, 1, 0, 0}, '{0, -2, 0, -2, 0}, '{-2, 8, 10, 8, -2},
				  '{0, -2, 0, -2, 0}, '{0, 0, 1, 0, 0}},
				'{'{0, 0, -2, 0, 0}, '{0, -2, 8, -2, 0}, '{1, 0, 10, 0, 1},
				  '{0, -2, 8, -2, 0}, '{0, 0, -2, 0, 0}},
				'{'{0, 0, -3, 0, 0}, '{0, 4, 0, 4, 0}, '{-3, 0, 12, 0, -3},
				  '{0, 4, 0, 4, 0}, '{0, 0, -3, 0, 0}}
			};
			foreach (store[i]) store[i] = '0;
			foreach (win[r, c]) win[r][c] = '0;
			width_reg  = LW_RESET;
			height_reg = FH_RESET;
			errors     = 0;
			clear_counters();
		endfunction

		function void clear_counters();
			in_row     = 0;
			in_column  = 0;
			out_row    = 0;
			out_column = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, cfg_data_t d);
			if (idx == REG_LINE_WIDTH) begin
				width_reg = d[LW_BITS-1:0];
			end else begin
				height_reg = d[FH_BITS-1:0];
			end
		endfunction

		function int eff_width();
			int w;
			w = int'(width_reg);
			if (w < 2) w = 2;
			if (w > BDM_MAX_WIDTH) w = BDM_MAX_WIDTH;
			return w;
		endfunction

		function int eff_height();
			int h;
			h = int'(height_reg);
			if (h < 2) h = 2;
			return h;
		endfunction

		// raster position of the next request; a frame cut short by a height at
		// or below the output row restarts from zero
		function int frame_pos();
			if (out_row >= eff_height()) return 0;
			return in_row * eff_width() + in_column;
		endfunction

		// taps outside the image are dropped, then round half up and clamp
		function field_t kernel_sum(kern_e k, int w, int h);
			int acc, r, c;
			acc = 0;
			for (int dy = 0; dy < 5; dy++) begin
				r = out_row + dy - 2;
				if (r < 0 || r >= h) continue;
				for (int dx = 0; dx < 5; dx++) begin
					c = out_column + dx - 2;
					if (c < 0 || c >= w) continue;
					acc += weights[k][dy][dx] * int'(win[dy][dx]);
				end
			end
			acc += 8;
			if (acc < 0) return '0;
			acc = acc / 16;
			if (acc > SAMPLE_MAX) acc = SAMPLE_MAX;
			return field_t'(acc);
		endfunction

		function void take_request(logic cmd, field_t smp);
			int     w, h, c, lin, nat, neigh;
			field_t value;
			field_t col[5];
			field_t rgb[3];
			pixel_t px;
			w = eff_width();
			h = eff_height();
			if (out_row >= h) clear_counters();
			if (in_row < h) begin
				if (cmd == CMD_FLUSH) return;
				value = smp;
			end else begin
				value = '0;
			end
			c = (in_column >= BDM_MAX_WIDTH) ? BDM_MAX_WIDTH - 1 : in_column;
			for (int r = 0; r < 4; r++) col[r] = store[r*BDM_MAX_WIDTH + c];
			col[4] = value;
			for (int r = 0; r < 4; r++) store[r*BDM_MAX_WIDTH + c] = col[r+1];
			for (int r = 0; r < 5; r++) begin
				for (int j = 0; j < 4; j++) win[r][j] = win[r][j+1];
				win[r][4] = col[r];
			end
			lin = in_row * w + in_column;
			in_column++;
			if (in_column >= w) begin
				in_column = 0;
				in_row++;
			end
			if (lin < 2*w + 2 || out_row >= h) return;

			if ((out_row & 1) != 0) begin
				nat = ((out_column & 1) != 0) ? CH_BLUE : CH_GREEN;
			end else begin
				nat = ((out_column & 1) != 0) ? CH_GREEN : CH_RED;
			end
			neigh = ((out_row & 1) != 0) ? CH_BLUE : CH_RED;
			for (int ch = 0; ch < 3; ch++) begin
				if (ch == nat) begin
					rgb[ch] = win[2][2];
				end else if (ch == CH_GREEN) begin
					rgb[ch] = kernel_sum(KERN_GREEN, w, h);
				end else if (nat != CH_GREEN) begin
					rgb[ch] = kernel_sum(KERN_DIAG, w, h);
				end else if (ch == neigh) begin
					rgb[ch] = kernel_sum(KERN_HORIZ, w, h);
				end else begin
					rgb[ch] = kernel_sum(KERN_VERT, w, h);
				end
			end
			px.red   = rgb[CH_RED];
			px.green = rgb[CH_GREEN];
			px.blue  = rgb[CH_BLUE];
			out_column++;
			if (out_column >= w) begin
				out_column = 0;
				out_row++;
			end
			if (out_row >= h) begin
				px.frame_end = 1'b1;
				clear_counters();
			end else begin
				px.frame_end = 1'b0;
			end
			pixels_due.push_back(px);
		endfunction

		function void compare(string what, logic [11:0] want, logic [11:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
				errors++;
			end
		endfunction

		function void check_pixel(field_t r, field_t g, field_t b, logic fe);
			pixel_t want;
			if (pixels_due.size() == 0) begin
				$display("%0t: pixel with no request pending: r=%0d g=%0d b=%0d fe=%0d",
					$time, r, g, b, fe);
				errors++;
				return;
			end
			want = pixels_due.pop_front();
			compare("red", want.red, r);
			compare("green", want.green, g);
			compare("blue", want.blue, b);
			compare("frame_end", {11'd0, want.frame_end}, {11'd0, fe});
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      cfg_valid;
	logic      cfg_ready;
	cfg_idx_t  cfg_index;
	cfg_data_t cfg_data;
	logic      sample_valid;
	logic      sample_stall;
	logic      command;
	field_t    raw_sample;
	logic      pixel_valid;
	logic      pixel_stall;
	field_t    red;
	field_t    green;
	field_t    blue;
	logic      frame_end;

	pixel_scoreboard sb;
	idle_e           send_mode = IDLE_NONE;
	idle_e           recv_mode = IDLE_NONE;
	int              items_sent = 0;
	int              cycle_count = 0;

	bayer_demosaic_5x5_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.command      (command),
		.raw_sample   (raw_sample),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.frame_end    (frame_end)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t: timeout, %0d pixels outstanding", $time, sb.pixels_due.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && !sample_stall) sb.take_request(command, raw_sample);
			if (pixel_valid && !pixel_stall) sb.check_pixel(red, green, blue, frame_end);
		end
	end

	function automatic int draw_gap(idle_e mode);
		case (mode)
			IDLE_FULL: begin
				return $urandom_range(0, 17);
			end
			IDLE_SPARSE: begin
				return ($urandom_range(0, 15) == 0) ? $urandom_range(1, 17) : 0;
			end
			default: begin
				return 0;
			end
		endcase
	endfunction

	// 0 uniform, 1 rails only (drives the clamps), otherwise a mix
	function automatic field_t draw_sample(int pat);
		if (pat == 1 || (pat > 1 && $urandom_range(0, 3) == 0)) begin
			return $urandom_range(0, 1) ? field_t'(SAMPLE_MAX) : '0;
		end
		return field_t'($urandom_range(0, SAMPLE_MAX));
	endfunction

	function automatic cfg_data_t pick_width();
		if ($urandom_range(0, 7) == 0) return cfg_data_t'($urandom_range(0, 1));
		return cfg_data_t'($urandom_range(2, 12));
	endfunction

	function automatic cfg_data_t pick_height();
		if ($urandom_range(0, 7) == 0) return cfg_data_t'($urandom_range(0, 1));
		return cfg_data_t'($urandom_range(2, 10));
	endfunction

	// sink side: stall for a random gap ahead of each pixel
	initial begin : pixel_sink
		int n;
		pixel_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			n = draw_gap(recv_mode);
			if (n > 0) begin
				pixel_stall <= 1'b1;
				repeat (n) @(posedge clk);
				pixel_stall <= 1'b0;
			end
			@(posedge clk);
			while (!pixel_valid) @(posedge clk);
		end
	end

	task automatic send_request(logic cmd, field_t smp);
		int gap;
		gap = draw_gap(send_mode);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		command      <= cmd;
		raw_sample   <= smp;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_idx_t idx, cfg_data_t d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, d);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// hold the sample channel until every pixel is out and the pipe is empty;
	// the monitor notes the last request before the pixel queue is polled
	task automatic settle();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (sb.pixels_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// n_live samples still belong to the frame; the rest are drain requests
	task automatic send_stream(int n_total, int n_live, int pat);
		for (int i = 0; i < n_total; i++) begin
			if (i < n_live) begin
				// flush while the frame is still coming in: ignored
				if ($urandom_range(0, 11) == 0) send_request(CMD_FLUSH, draw_sample(pat));
				send_request(CMD_SAMPLE, draw_sample(pat));
			end else begin
				// a sample while draining is dropped
				send_request($urandom_range(0, 3) == 0 ? CMD_SAMPLE : CMD_FLUSH,
					draw_sample(pat));
			end
			items_sent++;
		end
	endtask

	task automatic complete_frame(int pat);
		int w, h, pos;
		w   = sb.eff_width();
		h   = sb.eff_height();
		pos = sb.frame_pos();
		send_stream(h*w + 2*w + 2 - pos, (h*w > pos) ? h*w - pos : 0, pat);
		settle();
	endtask

	initial begin
		int  w, h, k, total, pat, kind;
		bit  first;
		sb = new();
		arst_n       <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= REG_LINE_WIDTH;
		cfg_data     <= '0;
		sample_valid <= 1'b0;
		command      <= CMD_SAMPLE;
		raw_sample   <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// smallest frame, rails on the samples
		send_mode = IDLE_FULL;
		recv_mode = IDLE_FULL;
		cfg_write(REG_LINE_WIDTH, 14'd2);
		cfg_write(REG_FRAME_HEIGHT, 14'd2);
		send_request(CMD_FLUSH, 12'hFFF);
		send_request(CMD_SAMPLE, 12'h000);
		send_request(CMD_SAMPLE, 12'hFFF);
		send_request(CMD_SAMPLE, 12'hFFF);
		send_request(CMD_SAMPLE, 12'h000);
		send_request(CMD_SAMPLE, 12'hAAA);
		repeat (5) send_request(CMD_FLUSH, 12'h555);
		settle();

		// register values below the minimum clamp to 2
		cfg_write(REG_LINE_WIDTH, 14'd0);
		cfg_write(REG_FRAME_HEIGHT, 14'd1);
		send_request(CMD_SAMPLE, 12'hFFF);
		send_request(CMD_SAMPLE, 12'h000);
		send_request(CMD_SAMPLE, 12'h555);
		send_request(CMD_SAMPLE, 12'hAAA);
		repeat (6) send_request(CMD_FLUSH, 12'h000);
		settle();

		first = 1'b1;
		while (items_sent < RANDOM_ITEMS) begin
			send_mode = idle_e'($urandom_range(0, 2));
			recv_mode = idle_e'($urandom_range(0, 2));
			pat = $urandom_range(0, 2);
			if ($urandom_range(0, 1)) cfg_write(REG_LINE_WIDTH, pick_width());
			if ($urandom_range(0, 1)) cfg_write(REG_FRAME_HEIGHT, pick_height());
			kind = first ? 19 : $urandom_range(0, 19);
			first = 1'b0;
			w = sb.eff_width();
			h = sb.eff_height();
			total = h*w + 2*w + 2;
			if (kind < 15) begin
				complete_frame(pat);
			end else if (kind < 18) begin
				// pause mid-frame, maybe move the height above the output row
				k = $urandom_range(1, total - 1);
				send_stream(k, (k < h*w) ? k : h*w, pat);
				settle();
				if ($urandom_range(0, 1)) begin
					cfg_write(REG_FRAME_HEIGHT,
						cfg_data_t'($urandom_range(sb.out_row + 1, sb.out_row + 6)));
				end
				complete_frame(pat);
			end else begin
				// drop the height to or below the output row: frame abandoned
				if (h < 3) begin
					cfg_write(REG_FRAME_HEIGHT, cfg_data_t'($urandom_range(3, 8)));
					h = sb.eff_height();
					total = h*w + 2*w + 2;
				end
				k = $urandom_range(4*w + 2, total - 1);
				send_stream(k, (k < h*w) ? k : h*w, pat);
				settle();
				cfg_write(REG_FRAME_HEIGHT, cfg_data_t'($urandom_range(0, sb.out_row)));
				complete_frame(pat);
			end
		end

		// tall narrow frame, idling kept light
		send_mode = IDLE_SPARSE;
		recv_mode = IDLE_SPARSE;
		cfg_write(REG_LINE_WIDTH, 14'd2);
		cfg_write(REG_FRAME_HEIGHT, 14'd190);
		complete_frame(2);

		if (sb.errors == 0 && sb.pixels_due.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
